### rtl/bstw_pkg.sv
// Shared types, codes and constants of the brush stamp tile writer.
`default_nettype none

package bstw_pkg;

  // Default sizes of the canvas and the brush.
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 128;
  localparam int MAX_STROKE_DEF  = 15;
  localparam int TILE_BITS_DEF   = 16;

  // Fixed widths of the channel fields and registers.
  localparam int POS_W    = 9;
  localparam int RTILE_W  = 16;
  localparam int DXY_W    = 7;
  localparam int DWH_W    = 8;
  localparam int MAPDIM_W = 8;
  localparam int STROKE_W = 4;
  localparam int BTILE_W  = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  // Reset values of the configuration registers.
  localparam logic [MAPDIM_W-1:0] MAP_WIDTH_RST   = 8'd128;
  localparam logic [MAPDIM_W-1:0] MAP_HEIGHT_RST  = 8'd128;
  localparam logic [STROKE_W-1:0] STROKE_SIZE_RST = 4'd1;
  localparam logic                CIRCLE_MODE_RST = 1'b0;
  localparam logic [BTILE_W-1:0]  BRUSH_TILE_RST  = 16'd0;

  // Operation codes of an input item.
  localparam logic FUNC_STAMP = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_HEIGHT  = 3'd1,
    REG_STROKE_SIZE = 3'd2,
    REG_CIRCLE_MODE = 3'd3,
    REG_BRUSH_TILE  = 3'd4
  } reg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STAMP,
    ST_READ,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic capture;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic stamp_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/bstw_in_if.sv
// Input channel carrying stamp and read items.
`default_nettype none

interface bstw_in_if;
  logic                            valid;
  logic                            ready;
  logic                            func;
  logic signed [bstw_pkg::POS_W-1:0] pos_x;
  logic signed [bstw_pkg::POS_W-1:0] pos_y;

  modport source (output valid, output func, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input func, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

### rtl/bstw_out_if.sv
// Output channel carrying one result per item.
`default_nettype none

interface bstw_out_if;
  logic                            valid;
  logic                            ready;
  logic [bstw_pkg::RTILE_W-1:0]    read_tile;
  logic [bstw_pkg::DXY_W-1:0]      dirty_x;
  logic [bstw_pkg::DXY_W-1:0]      dirty_y;
  logic [bstw_pkg::DWH_W-1:0]      dirty_w;
  logic [bstw_pkg::DWH_W-1:0]      dirty_h;

  modport source (output valid, output read_tile, output dirty_x, output dirty_y,
                  output dirty_w, output dirty_h, input ready);
  modport sink   (input valid, input read_tile, input dirty_x, input dirty_y,
                  input dirty_w, input dirty_h, output ready);
endinterface

`default_nettype wire

### rtl/bstw_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module bstw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read on one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### rtl/bstw_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module bstw_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bstw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bstw_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bstw_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  output logic      [bstw_pkg::MAPDIM_W-1:0] map_width,
  output logic      [bstw_pkg::MAPDIM_W-1:0] map_height,
  output logic      [bstw_pkg::STROKE_W-1:0] stroke_size,
  output logic                               circle_mode,
  output logic      [bstw_pkg::BTILE_W-1:0]  brush_tile
);
  import bstw_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width   <= MAP_WIDTH_RST;
      map_height  <= MAP_HEIGHT_RST;
      stroke_size <= STROKE_SIZE_RST;
      circle_mode <= CIRCLE_MODE_RST;
      brush_tile  <= BRUSH_TILE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAP_WIDTH:   map_width   <= pwdata[MAPDIM_W-1:0];
        REG_MAP_HEIGHT:  map_height  <= pwdata[MAPDIM_W-1:0];
        REG_STROKE_SIZE: stroke_size <= pwdata[STROKE_W-1:0];
        REG_CIRCLE_MODE: circle_mode <= pwdata[0];
        REG_BRUSH_TILE:  brush_tile  <= pwdata[BTILE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_MAP_WIDTH:   prdata = PDATA_W'(map_width);
      REG_MAP_HEIGHT:  prdata = PDATA_W'(map_height);
      REG_STROKE_SIZE: prdata = PDATA_W'(stroke_size);
      REG_CIRCLE_MODE: prdata = PDATA_W'(circle_mode);
      REG_BRUSH_TILE:  prdata = PDATA_W'(brush_tile);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bstw_ctrl.sv
// Controller state machine: clearing pass, item sequencing and result hand-off.
`default_nettype none

module bstw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  output logic                   in_ready,
  input  wire bstw_pkg::status_t stat,
  output bstw_pkg::cmd_t         cmd
);
  import bstw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (in_func == FUNC_READ) ? ST_READ : ST_STAMP;
      end
      ST_STAMP: begin
        if (stat.stamp_last) state_next = ST_FINISH;
      end
      ST_READ: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.clear   = (state == ST_CLEAR);
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.step    = (state == ST_STAMP);
    cmd.capture = (state == ST_FINISH) && stat.out_free;
  end

endmodule

`default_nettype wire

### rtl/bstw_dp.sv
// Datapath: brush offset counters, cell address, canvas RAM, bounding box, result register.
`default_nettype none

module bstw_dp #(
  parameter int MAX_COLUMNS = bstw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = bstw_pkg::MAX_ROWS_DEF,
  parameter int MAX_STROKE  = bstw_pkg::MAX_STROKE_DEF,
  parameter int TILE_BITS   = bstw_pkg::TILE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bstw_pkg::cmd_t                       cmd,
  output bstw_pkg::status_t                         stat,
  input  wire logic                                 in_func,
  input  wire logic signed [bstw_pkg::POS_W-1:0]    in_pos_x,
  input  wire logic signed [bstw_pkg::POS_W-1:0]    in_pos_y,
  input  wire logic        [bstw_pkg::MAPDIM_W-1:0] map_width,
  input  wire logic        [bstw_pkg::MAPDIM_W-1:0] map_height,
  input  wire logic        [bstw_pkg::STROKE_W-1:0] stroke_size,
  input  wire logic                                 circle_mode,
  input  wire logic        [bstw_pkg::BTILE_W-1:0]  brush_tile,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic             [bstw_pkg::RTILE_W-1:0]  out_read_tile,
  output logic             [bstw_pkg::DXY_W-1:0]    out_dirty_x,
  output logic             [bstw_pkg::DXY_W-1:0]    out_dirty_y,
  output logic             [bstw_pkg::DWH_W-1:0]    out_dirty_w,
  output logic             [bstw_pkg::DWH_W-1:0]    out_dirty_h
);
  import bstw_pkg::*;

  localparam int RW    = (MAX_STROKE / 2 > 0) ? $clog2(MAX_STROKE / 2 + 1) : 1;
  localparam int DW    = RW + 1;
  localparam int CW    = ((DW > POS_W) ? DW : POS_W) + 1;
  localparam int SQW   = 2 * RW + 1;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Item registers.
  logic                    func_q;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;
  logic        [RW-1:0]    r;
  logic signed [DW-1:0]    dx;
  logic signed [DW-1:0]    dy;

  // Bounding box of written cells.
  logic                    any;
  logic [MAPDIM_W-1:0]     minx;
  logic [MAPDIM_W-1:0]     maxx;
  logic [MAPDIM_W-1:0]     miny;
  logic [MAPDIM_W-1:0]     maxy;

  logic [AW-1:0]           clr_cnt;

  // Combinational terms.
  logic [MAPDIM_W-1:0]     eff_w;
  logic [MAPDIM_W-1:0]     eff_h;
  logic [STROKE_W-1:0]     eff_s;
  logic [RW-1:0]           r_new;
  logic signed [DW-1:0]    r_s;
  logic signed [DW-1:0]    r_new_s;
  logic signed [CW-1:0]    cx;
  logic signed [CW-1:0]    cy;
  logic signed [CW-1:0]    w_s;
  logic signed [CW-1:0]    h_s;
  logic                    on_map;
  logic [RW-1:0]           dx_mag;
  logic [RW-1:0]           dy_mag;
  logic [2*RW-1:0]         dx_sq;
  logic [2*RW-1:0]         dy_sq;
  logic [2*RW-1:0]         r_sq;
  logic [SQW-1:0]          offset_sq;
  logic                    circle_ok;
  logic [2*MAPDIM_W-1:0]   row_base;
  logic [AW-1:0]           cell_addr;
  logic                    cell_we;
  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [TILE_BITS-1:0]    ram_wdata;
  logic [TILE_BITS-1:0]    ram_rdata;

  // Effective map size and brush radius after saturation.
  assign eff_w   = (32'(map_width) > MAX_COLUMNS) ? MAPDIM_W'(MAX_COLUMNS) : map_width;
  assign eff_h   = (32'(map_height) > MAX_ROWS) ? MAPDIM_W'(MAX_ROWS) : map_height;
  assign eff_s   = (32'(stroke_size) > MAX_STROKE) ? STROKE_W'(MAX_STROKE) : stroke_size;
  assign r_new   = RW'(eff_s >> 1);
  assign r_s     = $signed({1'b0, r});
  assign r_new_s = $signed({1'b0, r_new});

  // Current cell and its position relative to the map.
  assign cx     = CW'(px) + CW'(dx);
  assign cy     = CW'(py) + CW'(dy);
  assign w_s    = $signed(CW'(eff_w));
  assign h_s    = $signed(CW'(eff_h));
  assign on_map = (cx >= 0) && (cx < w_s) && (cy >= 0) && (cy < h_s);

  // Round brush test on the offset.
  assign dx_mag    = (dx < 0) ? RW'(-dx) : RW'(dx);
  assign dy_mag    = (dy < 0) ? RW'(-dy) : RW'(dy);
  assign dx_sq     = dx_mag * dx_mag;
  assign dy_sq     = dy_mag * dy_mag;
  assign r_sq      = r * r;
  assign offset_sq = SQW'(dx_sq) + SQW'(dy_sq);
  assign circle_ok = !circle_mode || (offset_sq <= SQW'(r_sq));

  // Row-major cell address; an on-map cell always lands inside the store.
  assign row_base  = cy[MAPDIM_W-1:0] * eff_w;
  assign cell_addr = AW'((2*MAPDIM_W+1)'(row_base) + (2*MAPDIM_W+1)'(cx[MAPDIM_W-1:0]));
  assign cell_we   = cmd.step && on_map && circle_ok;

  // The clearing pass owns the RAM port after reset.
  assign ram_we    = cmd.clear || cell_we;
  assign ram_addr  = cmd.clear ? clr_cnt : cell_addr;
  assign ram_wdata = cmd.clear ? '0 : TILE_BITS'(brush_tile);

  bstw_ram #(
    .WIDTH (TILE_BITS),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Status back to the controller.
  assign stat.clear_last = (clr_cnt == AW'(DEPTH - 1));
  assign stat.stamp_last = (dx == r_s) && (dy == r_s);
  assign stat.out_free   = !out_valid || out_ready;

  // Clearing pass address counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Item capture and brush offset walk, row by row.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= in_func;
      px     <= in_pos_x;
      py     <= in_pos_y;
      r      <= r_new;
      if (in_func == FUNC_READ) begin
        dx <= '0;
        dy <= '0;
      end else begin
        dx <= -r_new_s;
        dy <= -r_new_s;
      end
    end else if (cmd.step) begin
      if (dx == r_s) begin
        dx <= -r_s;
        dy <= dy + $signed(DW'(1));
      end else begin
        dx <= dx + $signed(DW'(1));
      end
    end
  end

  // Bounding box of the cells written by a stamp.
  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (cmd.load) begin
      any <= 1'b0;
    end else if (cell_we) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      if (!any || (cx[MAPDIM_W-1:0] < minx)) minx <= cx[MAPDIM_W-1:0];
      if (!any || (cx[MAPDIM_W-1:0] > maxx)) maxx <= cx[MAPDIM_W-1:0];
      if (!any || (cy[MAPDIM_W-1:0] < miny)) miny <= cy[MAPDIM_W-1:0];
      if (!any || (cy[MAPDIM_W-1:0] > maxy)) maxy <= cy[MAPDIM_W-1:0];
    end
  end

  // Result register; it frees the input side while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_read_tile <= ((func_q == FUNC_READ) && on_map) ? RTILE_W'(ram_rdata) : '0;
      if (any) begin
        out_dirty_x <= minx[DXY_W-1:0];
        out_dirty_y <= miny[DXY_W-1:0];
        out_dirty_w <= DWH_W'(maxx - minx + MAPDIM_W'(1));
        out_dirty_h <= DWH_W'(maxy - miny + MAPDIM_W'(1));
      end else begin
        out_dirty_x <= '0;
        out_dirty_y <= '0;
        out_dirty_w <= '0;
        out_dirty_h <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/brush_stamp_tile_writer_core.sv
// Top level of the brush stamp tile writer: register file, controller and datapath.
//
// Usage: items arrive on stamp_in (valid/ready); a transfer with func = stamp
// paints brush_tile into every on-map cell of the square or round brush
// around (pos_x, pos_y); func = read fetches one tile. Every item yields one
// transfer on result_out with the tile read and the rectangle written.
// Registers are to be written through the APB-style port only while the block is
// idle; the block itself does not enforce this. A stamp walks the (2*r+1)^2 cells
// of the brush square, r = stroke_size/2, one cell per cycle through the single
// port of the canvas RAM; a read passes through the read state, which does the
// registered RAM read. Either then waits in the finish state until the result
// register is free, and loads it.
// Reset: the canvas, MAX_COLUMNS * MAX_ROWS cells (16384 by default), is swept
// to zero, one cell per cycle; stamp_in.ready stays low meanwhile.
// Stall: a finished result is held in an output register, so the next item
// is accepted while it waits; only the completion of that next item waits
// for result_out.ready.
`default_nettype none

module brush_stamp_tile_writer_core #(
  parameter int MAX_COLUMNS = bstw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = bstw_pkg::MAX_ROWS_DEF,
  parameter int MAX_STROKE  = bstw_pkg::MAX_STROKE_DEF,
  parameter int TILE_BITS   = bstw_pkg::TILE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bstw_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bstw_pkg::PDATA_W-1:0] pwdata,
  output logic      [bstw_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  bstw_in_if.sink                           stamp_in,
  bstw_out_if.source                        result_out
);
  import bstw_pkg::*;

  logic [MAPDIM_W-1:0] map_width;
  logic [MAPDIM_W-1:0] map_height;
  logic [STROKE_W-1:0] stroke_size;
  logic                circle_mode;
  logic [BTILE_W-1:0]  brush_tile;
  cmd_t                cmd;
  status_t             stat;
  logic                in_ready;

  assign stamp_in.ready = in_ready;

  bstw_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .map_width   (map_width),
    .map_height  (map_height),
    .stroke_size (stroke_size),
    .circle_mode (circle_mode),
    .brush_tile  (brush_tile)
  );

  bstw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stamp_in.valid),
    .in_func  (stamp_in.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bstw_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .MAX_STROKE  (MAX_STROKE),
    .TILE_BITS   (TILE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (stamp_in.func),
    .in_pos_x      (stamp_in.pos_x),
    .in_pos_y      (stamp_in.pos_y),
    .map_width     (map_width),
    .map_height    (map_height),
    .stroke_size   (stroke_size),
    .circle_mode   (circle_mode),
    .brush_tile    (brush_tile),
    .out_ready     (result_out.ready),
    .out_valid     (result_out.valid),
    .out_read_tile (result_out.read_tile),
    .out_dirty_x   (result_out.dirty_x),
    .out_dirty_y   (result_out.dirty_y),
    .out_dirty_w   (result_out.dirty_w),
    .out_dirty_h   (result_out.dirty_h)
  );

endmodule

`default_nettype wire

### verif/bstw_checker.sv
`timescale 1ns / 1ps
// Checker for the brush stamp tile writer: tracks register writes, predicts results and compares them.
module bstw_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [bstw_pkg::PADDR_W-1:0] paddr,
  input  logic [bstw_pkg::PDATA_W-1:0] pwdata,
  bstw_in_if                 stamp_ch,
  bstw_out_if                result_ch,
  output int                 fail_count,
  output int                 pending
);
  import bstw_pkg::*;

  localparam int CANVAS_DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF;

  // One predicted result: the tile read and the rectangle painted.
  typedef struct packed {
    logic [RTILE_W-1:0] read_tile;
    logic [DXY_W-1:0]   dirty_x;
    logic [DXY_W-1:0]   dirty_y;
    logic [DWH_W-1:0]   dirty_w;
    logic [DWH_W-1:0]   dirty_h;
  } outcome_t;

  logic [TILE_BITS_DEF-1:0] canvas [CANVAS_DEPTH];
  logic [MAPDIM_W-1:0]      cfg_cols;
  logic [MAPDIM_W-1:0]      cfg_rows;
  logic [STROKE_W-1:0]      cfg_stroke;
  logic                     cfg_round;
  logic [BTILE_W-1:0]       cfg_tile;
  outcome_t                 stamp_outcomes [$];
  int                       mismatches = 0;

  // Paints the brush into the canvas copy or fetches one tile, and returns the result.
  function automatic outcome_t paint_and_measure(input logic op,
                                                 input logic signed [POS_W-1:0] col_in,
                                                 input logic signed [POS_W-1:0] row_in);
    outcome_t res;
    int px, py, w, h, r, dx, dy, cx, cy, lo_x, hi_x, lo_y, hi_y;
    bit hit;
    res  = '0;
    px   = col_in;
    py   = row_in;
    w    = (cfg_cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cfg_cols);
    h    = (cfg_rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(cfg_rows);
    r    = ((cfg_stroke > MAX_STROKE_DEF) ? MAX_STROKE_DEF : int'(cfg_stroke)) / 2;
    hit  = 1'b0;
    lo_x = 0;
    hi_x = 0;
    lo_y = 0;
    hi_y = 0;
    if (op == FUNC_READ) begin
      if (px >= 0 && px < w && py >= 0 && py < h) begin
        res.read_tile = RTILE_W'(canvas[py * w + px]);
      end
    end else begin
      for (dy = -r; dy <= r; dy++) begin
        for (dx = -r; dx <= r; dx++) begin
          cx = px + dx;
          cy = py + dy;
          // Cells off the map, or outside the circle in round mode, are skipped.
          if (cx < 0 || cx >= w || cy < 0 || cy >= h) continue;
          if (cfg_round && (dx * dx + dy * dy > r * r)) continue;
          canvas[cy * w + cx] = cfg_tile[TILE_BITS_DEF-1:0];
          if (!hit) begin
            lo_x = cx;
            hi_x = cx;
            lo_y = cy;
            hi_y = cy;
            hit  = 1'b1;
          end else begin
            if (cx < lo_x) lo_x = cx;
            if (cx > hi_x) hi_x = cx;
            if (cy < lo_y) lo_y = cy;
            if (cy > hi_y) hi_y = cy;
          end
        end
      end
      if (hit) begin
        res.dirty_x = DXY_W'(lo_x);
        res.dirty_y = DXY_W'(lo_y);
        res.dirty_w = DWH_W'(hi_x - lo_x + 1);
        res.dirty_h = DWH_W'(hi_y - lo_y + 1);
      end
    end
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Register writes, result checks and predictions, all sampled at the rising edge.
  always @(posedge clk) begin
    outcome_t want;
    int i;
    if (rst) begin
      for (i = 0; i < CANVAS_DEPTH; i++) canvas[i] = '0;
      cfg_cols   = MAP_WIDTH_RST;
      cfg_rows   = MAP_HEIGHT_RST;
      cfg_stroke = STROKE_SIZE_RST;
      cfg_round  = CIRCLE_MODE_RST;
      cfg_tile   = BRUSH_TILE_RST;
      stamp_outcomes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[PADDR_W-1:2]))
          REG_MAP_WIDTH:   cfg_cols   = pwdata[MAPDIM_W-1:0];
          REG_MAP_HEIGHT:  cfg_rows   = pwdata[MAPDIM_W-1:0];
          REG_STROKE_SIZE: cfg_stroke = pwdata[STROKE_W-1:0];
          REG_CIRCLE_MODE: cfg_round  = pwdata[0];
          REG_BRUSH_TILE:  cfg_tile   = pwdata[BTILE_W-1:0];
          default: ;
        endcase
      end
      // The result transfer is checked before this edge's input is predicted.
      if (result_ch.valid && result_ch.ready) begin
        if (stamp_outcomes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tile 0x%0h rect %0d,%0d %0dx%0d",
                   $time, result_ch.read_tile, result_ch.dirty_x, result_ch.dirty_y,
                   result_ch.dirty_w, result_ch.dirty_h);
          mismatches++;
        end else begin
          want = stamp_outcomes.pop_front();
          check_field("read_tile", want.read_tile, result_ch.read_tile);
          check_field("dirty_x", want.dirty_x, result_ch.dirty_x);
          check_field("dirty_y", want.dirty_y, result_ch.dirty_y);
          check_field("dirty_w", want.dirty_w, result_ch.dirty_w);
          check_field("dirty_h", want.dirty_h, result_ch.dirty_h);
        end
      end
      if (stamp_ch.valid && stamp_ch.ready) begin
        stamp_outcomes.push_back(paint_and_measure(stamp_ch.func, stamp_ch.pos_x,
                                                   stamp_ch.pos_y));
      end
    end
    pending    <= stamp_outcomes.size();
    fail_count <= mismatches;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top of the brush stamp tile writer: stimulus, register writes and verdict.
module tb;
  import bstw_pkg::*;

  localparam int PHASES       = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic               pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               hold_go;
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_left;
  int                 cycles;
  int                 fail_count;
  int                 pending;
  int                 cur_cols;
  int                 cur_rows;
  int                 cur_reach;

  bstw_in_if  stamp_ch ();
  bstw_out_if result_ch ();

  brush_stamp_tile_writer_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .stamp_in   (stamp_ch),
    .result_out (result_ch)
  );

  bstw_checker canvas_check (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .stamp_ch   (stamp_ch),
    .result_ch  (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result receiver: random stalls, plus one long hold-off counted here.
  initial begin
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Run limit.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one item and returns at the edge of its transfer; valid stays high.
  task automatic offer_item(input logic op, input logic signed [POS_W-1:0] col,
                            input logic signed [POS_W-1:0] row);
    while ($urandom_range(99) < idle_pct) begin
      stamp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    stamp_ch.valid <= 1'b1;
    stamp_ch.func  <= op;
    stamp_ch.pos_x <= col;
    stamp_ch.pos_y <= row;
    @(posedge clk);
    while (!stamp_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every result has been taken.
  task automatic drain_results(input int extra);
    stamp_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One APB write: setup cycle, then access until pready.
  task automatic apb_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Programs all brush registers once the block is idle.
  task automatic set_brush(input logic [MAPDIM_W-1:0] cols, input logic [MAPDIM_W-1:0] rows,
                           input logic [STROKE_W-1:0] size, input logic round_brush,
                           input logic [BTILE_W-1:0] tile);
    drain_results(4);
    apb_write(REG_MAP_WIDTH, PDATA_W'(cols));
    apb_write(REG_MAP_HEIGHT, PDATA_W'(rows));
    apb_write(REG_STROKE_SIZE, PDATA_W'(size));
    apb_write(REG_CIRCLE_MODE, PDATA_W'(round_brush));
    apb_write(REG_BRUSH_TILE, PDATA_W'(tile));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    cur_cols  = (cols > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols);
    cur_rows  = (rows > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows);
    cur_reach = int'(size) / 2;
  endtask

  // Map dimension: mostly small maps so that reads land on painted cells.
  function automatic logic [MAPDIM_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return MAPDIM_W'($urandom_range(255, 129));
    else if (sel == 1) return MAPDIM_W'(1);
    else if (sel == 2) return MAPDIM_W'(128);
    else if (sel < 10) return MAPDIM_W'($urandom_range(24, 1));
    else return MAPDIM_W'($urandom_range(128, 1));
  endfunction

  // Coordinate: near the last stamp, around the map, or anywhere in the field.
  function automatic logic signed [POS_W-1:0] pick_coord(input int span, input int near_c,
                                                         input int reach);
    int sel;
    sel = $urandom_range(99);
    if (sel < 15) return POS_W'($urandom);
    else if (sel < 45) return POS_W'(near_c + int'($urandom_range(2 * reach + 2)) - reach - 1);
    else return POS_W'(int'($urandom_range(span + 15)) - 8);
  endfunction

  // Main stimulus.
  initial begin
    int ph, n, lx, ly;
    logic op;
    logic signed [POS_W-1:0] px, py;
    logic [MAPDIM_W-1:0] wv, hv;
    logic [STROKE_W-1:0] sv;
    logic cv;

    stamp_ch.valid <= 1'b0;
    stamp_ch.func  <= FUNC_STAMP;
    stamp_ch.pos_x <= '0;
    stamp_ch.pos_y <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    hold_go <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    cur_cols  = MAP_WIDTH_RST;
    cur_rows  = MAP_HEIGHT_RST;
    cur_reach = STROKE_SIZE_RST / 2;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, then clipped and empty stamps and reads at the field extremes.
    offer_item(FUNC_READ, 9'sd0, 9'sd0);
    offer_item(FUNC_STAMP, 9'sd5, 9'sd5);
    set_brush(8'd128, 8'd128, 4'd15, 1'b0, 16'hFFFF);
    offer_item(FUNC_STAMP, 9'sd0, 9'sd0);
    offer_item(FUNC_STAMP, 9'sd127, 9'sd127);
    offer_item(FUNC_STAMP, -9'sd256, -9'sd256);
    offer_item(FUNC_STAMP, 9'sd255, 9'sd255);
    offer_item(FUNC_STAMP, -9'sd7, 9'sd64);
    offer_item(FUNC_READ, 9'sd127, 9'sd127);
    offer_item(FUNC_READ, 9'sd128, 9'sd0);
    offer_item(FUNC_READ, -9'sd1, 9'sd0);
    offer_item(FUNC_READ, 9'sd0, -9'sd256);
    offer_item(FUNC_READ, 9'sd255, 9'sd255);
    offer_item(FUNC_READ, 9'sd3, 9'sd3);
    // Round brush: the corner of the square stays unpainted.
    set_brush(8'd128, 8'd128, 4'd14, 1'b1, 16'hA5C3);
    offer_item(FUNC_STAMP, 9'sd64, 9'sd64);
    offer_item(FUNC_READ, 9'sd57, 9'sd64);
    offer_item(FUNC_READ, 9'sd58, 9'sd58);
    offer_item(FUNC_READ, 9'sd64, 9'sd71);
    // Empty map with an oversized height.
    set_brush(8'd0, 8'd200, 4'd0, 1'b0, 16'h5A5A);
    offer_item(FUNC_STAMP, 9'sd0, 9'sd0);
    offer_item(FUNC_READ, 9'sd0, 9'sd0);
    // Oversized width on a single row.
    set_brush(8'd255, 8'd1, 4'd3, 1'b1, 16'h0001);
    offer_item(FUNC_STAMP, 9'sd127, 9'sd0);
    offer_item(FUNC_READ, 9'sd127, 9'sd0);
    offer_item(FUNC_READ, 9'sd127, 9'sd1);

    // Random phases, each with its own brush settings and idling pattern.
    lx = 0;
    ly = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin wv = 8'd128; hv = 8'd128; sv = 4'd1;  cv = 1'b0; end
        1: begin wv = 8'd1;   hv = 8'd128; sv = 4'd15; cv = 1'b1; end
        2: begin wv = 8'd128; hv = 8'd1;   sv = 4'd14; cv = 1'b0; end
        3: begin wv = pick_dim(); hv = 8'd0; sv = 4'd4; cv = 1'b1; end
        4: begin wv = 8'd255; hv = 8'd200; sv = 4'd5; cv = 1'b0; end
        default: begin
          wv = pick_dim();
          hv = pick_dim();
          sv = ($urandom_range(3) == 0) ? STROKE_W'($urandom_range(15))
                                        : STROKE_W'($urandom_range(5));
          cv = 1'($urandom_range(1));
        end
      endcase
      set_brush(wv, hv, sv, cv, BTILE_W'($urandom));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      // In the first phase the receiver holds off while items keep coming.
      if (ph == 0) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < 55) ? FUNC_STAMP : FUNC_READ;
        px = pick_coord(cur_cols, lx, cur_reach);
        py = pick_coord(cur_rows, ly, cur_reach);
        if (op == FUNC_STAMP) begin
          lx = px;
          ly = py;
        end
        offer_item(op, px, py);
      end
    end

    drain_results(DRAIN_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### brush_stamp_tile_writer_core.f
rtl/bstw_pkg.sv
rtl/bstw_in_if.sv
rtl/bstw_out_if.sv
rtl/bstw_ram.sv
rtl/bstw_regs.sv
rtl/bstw_ctrl.sv
rtl/bstw_dp.sv
rtl/brush_stamp_tile_writer_core.sv
verif/bstw_checker.sv
verif/tb.sv
